>>> rtl/vcoe_pkg.sv
`default_nettype none

package vcoe_pkg;

    // Field widths
    localparam int unsigned CUBE_W   = 10;
    localparam int unsigned CELL_W   = 12;
    localparam int unsigned RES_W    = 13;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned COORD_W  = 30;
    localparam int unsigned MASK_W   = 64;
    localparam int unsigned BIT_W    = 6;
    localparam int unsigned STAT_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // Register reset values
    localparam logic [RES_W-1:0]  GRID_RES_RESET = 13'd64;
    localparam logic [WORD_W-1:0] ATTR_CNT_RESET = 32'd0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_RES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTR_CNT = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ATTR = 2'd1;
    localparam logic [STAT_W-1:0] STAT_GRID = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_state;

    // Cell under test, from sequencer to check unit
    typedef struct packed {
        logic [CELL_W-1:0] x;
        logic [CELL_W-1:0] y;
        logic [CELL_W-1:0] z;
        logic [WORD_W-1:0] idx;
    } t_cell_req;

    // Emit control, from sequencer to output register
    typedef struct packed {
        logic load;
        logic last;
    } t_emit;

endpackage

`default_nettype wire

>>> rtl/vcoe_check.sv
`default_nettype none

module vcoe_check
    import vcoe_pkg::*;
(
    input  wire t_cell_req         i_req,
    input  wire logic [RES_W-1:0]  i_grid_res,
    input  wire logic [WORD_W-1:0] i_attr_cnt,
    output logic [STAT_W-1:0]      o_status
);

    logic attr_bad;
    logic grid_bad;

    // Attribute bound first, then all three axes against the grid
    assign attr_bad = (i_req.idx >= i_attr_cnt);
    assign grid_bad = ({1'b0, i_req.x} >= i_grid_res) ||
                      ({1'b0, i_req.y} >= i_grid_res) ||
                      ({1'b0, i_req.z} >= i_grid_res);

    always_comb begin
        if (attr_bad) begin
            o_status = STAT_ATTR;
        end else if (grid_bad) begin
            o_status = STAT_GRID;
        end else begin
            o_status = STAT_OK;
        end
    end

endmodule

`default_nettype wire

>>> rtl/vcoe_seq.sv
`default_nettype none

module vcoe_seq
    import vcoe_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [COORD_W-1:0] i_cube_coord,
    input  wire logic [MASK_W-1:0]  i_occupancy_mask,
    input  wire logic [WORD_W-1:0]  i_first_attribute,
    input  wire logic [WORD_W-1:0]  i_bone_index,
    input  wire logic [WORD_W-1:0]  i_refined_group,
    input  wire logic               i_out_free,
    input  wire logic [STAT_W-1:0]  i_status,
    output t_cell_req               o_req,
    output t_emit                   o_emit,
    output logic [WORD_W-1:0]       o_bone,
    output logic [WORD_W-1:0]       o_group
);

    t_state              r_state, n_state;
    logic [MASK_W-1:0]   r_mask;
    logic [BIT_W-1:0]    r_bit;
    logic [WORD_W-1:0]   r_idx;
    logic [CUBE_W-1:0]   r_cx, r_cy, r_cz;
    logic [WORD_W-1:0]   r_bone;
    logic [WORD_W-1:0]   r_group;

    logic accept;
    logic scan;
    logic cur_set;
    logic rest_empty;
    logic fire;
    logic done;

    assign accept     = i_in_valid && !o_in_stall;
    assign scan       = (r_state == ST_SCAN);
    assign cur_set    = r_mask[0];
    assign rest_empty = (r_mask[MASK_W-1:1] == '0);
    assign fire       = scan && cur_set && i_out_free;
    // Cube ends on an error, or on the last set bit
    assign done       = fire && ((i_status != STAT_OK) || rest_empty);

    assign o_in_stall = !(r_state == ST_IDLE);

    // Cell position: cube index times four plus the brick sub-position
    assign o_req.x   = {r_cx, r_bit[1:0]};
    assign o_req.y   = {r_cy, r_bit[3:2]};
    assign o_req.z   = {r_cz, r_bit[5:4]};
    assign o_req.idx = r_idx;

    assign o_emit.load = fire;
    assign o_emit.last = (i_status != STAT_OK) || rest_empty;
    assign o_bone      = r_bone;
    assign o_group     = r_group;

    // State sequencing
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_occupancy_mask != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (done || (!cur_set && rest_empty)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Cube context and mask walker
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mask  <= i_occupancy_mask;
            r_bit   <= '0;
            r_idx   <= i_first_attribute;
            r_cx    <= i_cube_coord[CUBE_W-1:0];
            r_cy    <= i_cube_coord[2*CUBE_W-1:CUBE_W];
            r_cz    <= i_cube_coord[3*CUBE_W-1:2*CUBE_W];
            r_bone  <= i_bone_index;
            r_group <= i_refined_group;
        end else if (scan && (!cur_set || fire)) begin
            r_mask <= r_mask >> 1;
            r_bit  <= r_bit + 1'b1;
            if (fire) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/voxel_cube_occupancy_expander.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------------
// cube in  | input     | i_in_valid / o_in_stall| cube_coord, occupancy_mask, first_attr..
// cell out | output    | o_out_valid/i_out_stall| cell_x/y/z, sample_index, bone, group..
// config   | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
// A cube is walked from bit 0 up to its highest set bit, or up to the failing cell,
// by the single-bit mask walker and its shared check unit.
// An empty mask gives no beat.
// Output stall holds the walker on a set bit until the output register frees.
// Synchronous active-low reset; registers return to resolution 64, count 0.
`default_nettype none

module voxel_cube_occupancy_expander
    import vcoe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Cube input
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [COORD_W-1:0]   i_cube_coord,
    input  wire logic [MASK_W-1:0]    i_occupancy_mask,
    input  wire logic [WORD_W-1:0]    i_first_attribute,
    input  wire logic [WORD_W-1:0]    i_bone_index,
    input  wire logic [WORD_W-1:0]    i_refined_group,
    // Cell output
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [CELL_W-1:0]         o_cell_x,
    output logic [CELL_W-1:0]         o_cell_y,
    output logic [CELL_W-1:0]         o_cell_z,
    output logic [WORD_W-1:0]         o_sample_index,
    output logic [WORD_W-1:0]         o_cell_bone,
    output logic [WORD_W-1:0]         o_cell_group,
    output logic [STAT_W-1:0]         o_status,
    output logic                      o_last,
    // Configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    logic [RES_W-1:0]  r_grid_res;
    logic [WORD_W-1:0] r_attr_cnt;
    logic              r_out_valid;

    t_cell_req         req;
    t_emit             emit;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] bone;
    logic [WORD_W-1:0] group;
    logic              out_free;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_res <= GRID_RES_RESET;
            r_attr_cnt <= ATTR_CNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_RES: r_grid_res <= i_cfg_data[RES_W-1:0];
                CFG_ATTR_CNT: r_attr_cnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vcoe_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cube_coord      (i_cube_coord),
        .i_occupancy_mask  (i_occupancy_mask),
        .i_first_attribute (i_first_attribute),
        .i_bone_index      (i_bone_index),
        .i_refined_group   (i_refined_group),
        .i_out_free        (out_free),
        .i_status          (status),
        .o_req             (req),
        .o_emit            (emit),
        .o_bone            (bone),
        .o_group           (group)
    );

    vcoe_check u_check (
        .i_req      (req),
        .i_grid_res (r_grid_res),
        .i_attr_cnt (r_attr_cnt),
        .o_status   (status)
    );

    // Output register: free when empty or its beat is taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.load) begin
            o_cell_x       <= req.x;
            o_cell_y       <= req.y;
            o_cell_z       <= req.z;
            o_sample_index <= req.idx;
            o_cell_bone    <= bone;
            o_cell_group   <= group;
            o_status       <= status;
            o_last         <= emit.last;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> rtl/vcoe_checker.sv
`default_nettype none

module vcoe_checker
    import vcoe_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic [MASK_W-1:0]    i_occupancy_mask,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [CELL_W-1:0]    o_cell_x,
    input wire logic [WORD_W-1:0]    o_sample_index,
    input wire logic [STAT_W-1:0]    o_status,
    input wire logic                 o_last
);

    // A stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cell_x) &&
        $stable(o_sample_index) && $stable(o_status) && $stable(o_last))
        else $error("stalled output beat changed");

    // Any error beat closes the cube
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_OK) |-> o_last)
        else $error("error beat without last");

    // Status code stays within the defined set
    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STAT_OK) || (o_status == STAT_ATTR) ||
        (o_status == STAT_GRID))
        else $error("undefined status code");

    // A cube with set bits keeps the input side busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_occupancy_mask != '0) |=> o_in_stall)
        else $error("input taken again while cube in progress");

    // Reset empties the output
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind voxel_cube_occupancy_expander vcoe_checker u_vcoe_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_occupancy_mask (i_occupancy_mask),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_cell_x         (o_cell_x),
    .o_sample_index   (o_sample_index),
    .o_status         (o_status),
    .o_last           (o_last)
);

`default_nettype wire
